[hw/rtl/eipl4_pkg.sv]
// ----------------------------------------------------------------------------
// eipl4_pkg
// Shared types and constants for the Ethernet / IP / L4 header parser.
// ----------------------------------------------------------------------------
package eipl4_pkg;

    localparam logic [7:0]  ETYPE_HI_OFS   = 8'd12;
    localparam logic [7:0]  ETYPE_LO_OFS   = 8'd13;
    localparam logic [4:0]  ETH_HDR_BYTES  = 5'd14;
    localparam logic [4:0]  TAG_BYTES      = 5'd4;
    localparam logic [5:0]  V6_HDR_BYTES   = 6'd40;
    localparam logic [6:0]  MIN_HDR_BYTES  = 7'd20;
    localparam logic [16:0] UDP_HDR_BYTES  = 17'd8;
    localparam logic [15:0] MAX_8023_LEN   = 16'h05dc;

    localparam logic [15:0] ETYPE_IPV4     = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6     = 16'h86dd;
    localparam logic [15:0] ETYPE_VLAN     = 16'h8100;
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [15:0] ETYPE_RARP     = 16'h8035;
    localparam logic [15:0] ETYPE_LOOPBACK = 16'h9000;

    localparam logic [7:0]  PROTO_HOPOPT   = 8'd0;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam logic [3:0]  CLS_TCP        = 4'd0;
    localparam logic [3:0]  CLS_UDP        = 4'd1;
    localparam logic [3:0]  CLS_ICMP       = 4'd2;
    localparam logic [3:0]  CLS_IP_PROTO0  = 4'd3;
    localparam logic [3:0]  CLS_OTHER_IP   = 4'd4;
    localparam logic [3:0]  CLS_8023       = 4'd5;
    localparam logic [3:0]  CLS_ARP        = 4'd6;
    localparam logic [3:0]  CLS_RARP       = 4'd7;
    localparam logic [3:0]  CLS_LOOPBACK   = 4'd8;
    localparam logic [3:0]  CLS_UNKNOWN    = 4'd9;

    localparam logic [1:0]  ST_OK          = 2'd0;
    localparam logic [1:0]  ST_BAD_IP_HDR  = 2'd1;
    localparam logic [1:0]  ST_BAD_TCP_HDR = 2'd2;
    localparam logic [1:0]  ST_SHORT       = 2'd3;

    typedef enum logic [1:0] {
        L3_NONE = 2'd0,
        L3_IPV4 = 2'd1,
        L3_IPV6 = 2'd2
    } t_l3_kind;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        logic [15:0] wire_length;
    } t_beat;

    typedef struct packed {
        logic [15:0] ether_kind;
        logic        vlan_seen;
        t_l3_kind    l3_kind;
        logic [5:0]  ip_header_bytes;
        logic [16:0] ip_total_bytes;
        logic [7:0]  ip_protocol_num;
        logic [6:0]  tcp_header_bytes;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [7:0]  tcp_ctl;
        logic [15:0] ip_ident;
        logic [7:0]  ip_tos;
        logic [31:0] tcp_seq;
        logic [31:0] tcp_ack;
        logic [7:0]  ip_ttl;
    } t_hdr_state;

endpackage

[hw/rtl/ethernet_ip_l4_header_parser.sv]
// ----------------------------------------------------------------------------
// ethernet_ip_l4_header_parser
// Byte-wide Ethernet / 802.1Q / IPv4 / IPv6 / TCP / UDP header parser that
// emits one classification record per frame.
// ----------------------------------------------------------------------------
// Takes one frame byte per clock, starting at the destination MAC, with a
// last-byte mark and the wire length on the last byte. Each byte passes an
// input register, then one combinational pass updates the header capture
// state; on the last byte the record is formed in the same pass and lands in
// the result register, from which the record is offered. Throughput is one
// byte per cycle; the input stalls only while a last byte waits for a result
// register that is still held by a stall on the output side. Frames of any
// length are accepted; offsets past 255 are not examined.
// ----------------------------------------------------------------------------
module ethernet_ip_l4_header_parser
    import eipl4_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_is_last,
    input  logic [15:0]        i_wire_length,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [3:0]         o_frame_class,
    output logic [1:0]         o_status,
    output logic [15:0]        o_frame_length,
    output logic [15:0]        o_source_port,
    output logic [15:0]        o_dest_port,
    output logic [7:0]         o_tcp_flag_bits,
    output logic [31:0]        o_tcp_sequence,
    output logic [31:0]        o_tcp_acknowledge,
    output logic [15:0]        o_ip_ident,
    output logic [7:0]         o_ip_service_type,
    output logic [7:0]         o_ip_hop_limit,
    output logic signed [16:0] o_payload_length
);

    logic       w_out_free;
    logic       w_adv;
    t_beat      w_beat;
    t_hdr_state w_next;
    logic [8:0] w_n;

    eipl4_in_stage u_in_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_is_last     (i_is_last),
        .i_wire_length (i_wire_length),
        .i_out_free    (w_out_free),
        .o_stall       (o_in_stall),
        .o_adv         (w_adv),
        .o_beat        (w_beat)
    );

    eipl4_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_beat  (w_beat),
        .o_next  (w_next),
        .o_n     (w_n)
    );

    eipl4_record u_record (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load            (w_adv && w_beat.is_last),
        .i_hdr             (w_next),
        .i_n               (w_n),
        .i_wire_length     (w_beat.wire_length),
        .i_out_stall       (i_out_stall),
        .o_out_free        (w_out_free),
        .o_out_valid       (o_out_valid),
        .o_frame_class     (o_frame_class),
        .o_status          (o_status),
        .o_frame_length    (o_frame_length),
        .o_source_port     (o_source_port),
        .o_dest_port       (o_dest_port),
        .o_tcp_flag_bits   (o_tcp_flag_bits),
        .o_tcp_sequence    (o_tcp_sequence),
        .o_tcp_acknowledge (o_tcp_acknowledge),
        .o_ip_ident        (o_ip_ident),
        .o_ip_service_type (o_ip_service_type),
        .o_ip_hop_limit    (o_ip_hop_limit),
        .o_payload_length  (o_payload_length)
    );

`ifndef SYNTHESIS
    a_last_loads_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_beat.is_last) |=> o_out_valid)
        else $error("last byte did not produce a record");

    a_short_is_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_SHORT) |->
        (o_frame_class == CLS_UNKNOWN && o_source_port == 16'h0000 &&
         o_ip_ident == 16'h0000 && o_payload_length == 17'sd0))
        else $error("cut-short frame carries captured fields");

    a_bad_ip_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_BAD_IP_HDR) |->
        (o_frame_class == CLS_OTHER_IP && o_ip_hop_limit == 8'h00 &&
         o_tcp_sequence == 32'h0))
        else $error("bad IP header record carries captured fields");

    a_record_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_frame_class) &&
         $stable(o_tcp_sequence) && $stable(o_payload_length)))
        else $error("stalled record changed");
`endif

endmodule

[hw/rtl/eipl4_in_stage.sv]
// ----------------------------------------------------------------------------
// eipl4_in_stage
// Input register for frame bytes; holds a last byte while the result
// register is still occupied.
// ----------------------------------------------------------------------------
module eipl4_in_stage
    import eipl4_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    input  logic [15:0] i_wire_length,
    input  logic        i_out_free,
    output logic        o_stall,
    output logic        o_adv,
    output t_beat       o_beat
);

    logic  r_valid;
    t_beat r_beat;

    assign o_adv   = r_valid && (!r_beat.is_last || i_out_free);
    assign o_stall = r_valid && !o_adv;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_beat <= '{data_byte: i_data_byte, is_last: i_is_last,
                        wire_length: i_wire_length};
        end
    end

endmodule

[hw/rtl/eipl4_parse.sv]
// ----------------------------------------------------------------------------
// eipl4_parse
// Byte offset counter and header field capture. Presents the header state
// as it stands after the current byte.
// ----------------------------------------------------------------------------
module eipl4_parse
    import eipl4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_adv,
    input  t_beat      i_beat,
    output t_hdr_state o_next,
    output logic [8:0] o_n
);

    logic [7:0] r_offset;
    t_hdr_state r_state;
    t_hdr_state n_state;

    always_comb begin
        t_hdr_state cur;
        logic [7:0] b;
        logic [4:0] s;
        logic [7:0] r;
        logic [7:0] q;
        logic       done;

        cur  = (r_offset == 8'd0) ? '0 : r_state;
        b    = i_beat.data_byte;
        s    = cur.vlan_seen ? (ETH_HDR_BYTES + TAG_BYTES) : ETH_HDR_BYTES;
        r    = '0;
        q    = '0;
        done = 1'b0;
        n_state = cur;

        if (r_offset == ETYPE_HI_OFS) begin
            n_state.ether_kind = {b, 8'h00};
        end else if (r_offset == ETYPE_LO_OFS) begin
            n_state.ether_kind = cur.ether_kind | {8'h00, b};
            if (n_state.ether_kind == ETYPE_VLAN) begin
                n_state.vlan_seen = 1'b1;
                n_state.l3_kind   = L3_IPV4;
            end else if (n_state.ether_kind == ETYPE_IPV4) begin
                n_state.l3_kind   = L3_IPV4;
            end else if (n_state.ether_kind == ETYPE_IPV6) begin
                n_state.l3_kind         = L3_IPV6;
                n_state.ip_header_bytes = V6_HDR_BYTES;
            end
        end else if (cur.l3_kind != L3_NONE && r_offset >= {3'b000, s}) begin
            r = r_offset - {3'b000, s};
            if (cur.l3_kind == L3_IPV4) begin
                case (r)
                    8'd0: n_state.ip_header_bytes = {b[3:0], 2'b00};
                    8'd1: n_state.ip_tos = b;
                    8'd2: n_state.ip_total_bytes = {1'b0, b, 8'h00};
                    8'd3: n_state.ip_total_bytes = cur.ip_total_bytes | {9'h000, b};
                    8'd4: n_state.ip_ident[15:8] = b;
                    8'd5: n_state.ip_ident[7:0] = b;
                    8'd8: n_state.ip_ttl = b;
                    8'd9: n_state.ip_protocol_num = b;
                    default: ;
                endcase
                if ({1'b0, n_state.ip_header_bytes} < MIN_HDR_BYTES) begin
                    done = 1'b1;
                end
            end else begin
                case (r)
                    8'd4: n_state.ip_total_bytes = {1'b0, b, 8'h00};
                    8'd5: n_state.ip_total_bytes = (cur.ip_total_bytes | {9'h000, b})
                                                   + {11'h000, V6_HDR_BYTES};
                    8'd6: n_state.ip_protocol_num = b;
                    default: ;
                endcase
            end
            if (!done && r >= {2'b00, n_state.ip_header_bytes}) begin
                q = r - {2'b00, n_state.ip_header_bytes};
                if (n_state.ip_protocol_num == PROTO_TCP) begin
                    case (q)
                        8'd0:  n_state.l4_sport[15:8] = b;
                        8'd1:  n_state.l4_sport[7:0]  = b;
                        8'd2:  n_state.l4_dport[15:8] = b;
                        8'd3:  n_state.l4_dport[7:0]  = b;
                        8'd4:  n_state.tcp_seq[31:24] = b;
                        8'd5:  n_state.tcp_seq[23:16] = b;
                        8'd6:  n_state.tcp_seq[15:8]  = b;
                        8'd7:  n_state.tcp_seq[7:0]   = b;
                        8'd8:  n_state.tcp_ack[31:24] = b;
                        8'd9:  n_state.tcp_ack[23:16] = b;
                        8'd10: n_state.tcp_ack[15:8]  = b;
                        8'd11: n_state.tcp_ack[7:0]   = b;
                        8'd12: n_state.tcp_header_bytes = {1'b0, b[7:4], 2'b00};
                        8'd13: n_state.tcp_ctl = b;
                        default: ;
                    endcase
                end else if (n_state.ip_protocol_num == PROTO_UDP) begin
                    case (q)
                        8'd0: n_state.l4_sport[15:8] = b;
                        8'd1: n_state.l4_sport[7:0]  = b;
                        8'd2: n_state.l4_dport[15:8] = b;
                        8'd3: n_state.l4_dport[7:0]  = b;
                        default: ;
                    endcase
                end
            end
        end
    end

    assign o_next = n_state;
    assign o_n    = {1'b0, r_offset} + 9'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_state  <= '0;
        end else if (i_adv) begin
            if (i_beat.is_last) begin
                r_offset <= '0;
                r_state  <= '0;
            end else begin
                r_state <= n_state;
                if (r_offset != 8'hff) begin
                    r_offset <= r_offset + 8'd1;
                end
            end
        end
    end

endmodule

[hw/rtl/eipl4_record.sv]
// ----------------------------------------------------------------------------
// eipl4_record
// Classifies the finished frame and holds its record in the result register.
// ----------------------------------------------------------------------------
module eipl4_record
    import eipl4_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_hdr_state         i_hdr,
    input  logic [8:0]         i_n,
    input  logic [15:0]        i_wire_length,
    input  logic               i_out_stall,
    output logic               o_out_free,
    output logic               o_out_valid,
    output logic [3:0]         o_frame_class,
    output logic [1:0]         o_status,
    output logic [15:0]        o_frame_length,
    output logic [15:0]        o_source_port,
    output logic [15:0]        o_dest_port,
    output logic [7:0]         o_tcp_flag_bits,
    output logic [31:0]        o_tcp_sequence,
    output logic [31:0]        o_tcp_acknowledge,
    output logic [15:0]        o_ip_ident,
    output logic [7:0]         o_ip_service_type,
    output logic [7:0]         o_ip_hop_limit,
    output logic signed [16:0] o_payload_length
);

    logic        r_out_valid;
    logic [3:0]  r_frame_class;
    logic [1:0]  r_status;
    logic [15:0] r_frame_length;
    logic [15:0] r_source_port;
    logic [15:0] r_dest_port;
    logic [7:0]  r_tcp_flag_bits;
    logic [31:0] r_tcp_sequence;
    logic [31:0] r_tcp_acknowledge;
    logic [15:0] r_ip_ident;
    logic [7:0]  r_ip_service_type;
    logic [7:0]  r_ip_hop_limit;
    logic [16:0] r_payload_length;

    logic [3:0]  n_cls;
    logic [1:0]  n_st;
    logic        n_v4;
    logic        n_l4;
    logic        n_tcp_ok;
    logic [16:0] n_pay;

    always_comb begin
        logic [8:0] s9;
        logic [8:0] l4s;
        logic       ip_bad;

        s9       = i_hdr.vlan_seen ? {4'h0, ETH_HDR_BYTES + TAG_BYTES}
                                   : {4'h0, ETH_HDR_BYTES};
        l4s      = s9 + {3'b000, i_hdr.ip_header_bytes};
        ip_bad   = {1'b0, i_hdr.ip_header_bytes} < MIN_HDR_BYTES;
        n_cls    = CLS_UNKNOWN;
        n_st     = ST_OK;
        n_v4     = 1'b0;
        n_l4     = 1'b0;
        n_tcp_ok = 1'b0;
        n_pay    = '0;

        if (i_n < {4'h0, ETH_HDR_BYTES}) begin
            n_st = ST_SHORT;
        end else if (i_hdr.l3_kind != L3_NONE) begin
            if (i_hdr.l3_kind == L3_IPV4 && i_n < s9 + 9'd1) begin
                n_st = ST_SHORT;
            end else if (i_hdr.l3_kind == L3_IPV4 && ip_bad) begin
                n_st  = ST_BAD_IP_HDR;
                n_cls = CLS_OTHER_IP;
            end else if (i_hdr.l3_kind == L3_IPV4 && i_n < s9 + 9'd10) begin
                n_st = ST_SHORT;
            end else if (i_hdr.l3_kind != L3_IPV4 && i_n < s9 + 9'd7) begin
                n_st = ST_SHORT;
            end else begin
                n_v4 = (i_hdr.l3_kind == L3_IPV4);
                if (i_hdr.ip_protocol_num == PROTO_TCP) begin
                    if (i_n < l4s + 9'd13) begin
                        n_st = ST_SHORT;
                    end else if (i_hdr.tcp_header_bytes < MIN_HDR_BYTES) begin
                        n_st  = ST_BAD_TCP_HDR;
                        n_cls = CLS_TCP;
                    end else if (i_n < l4s + 9'd14) begin
                        n_st = ST_SHORT;
                    end else begin
                        n_cls    = CLS_TCP;
                        n_l4     = 1'b1;
                        n_tcp_ok = 1'b1;
                        n_pay    = i_hdr.ip_total_bytes
                                   - ({11'h000, i_hdr.ip_header_bytes}
                                      + {10'h000, i_hdr.tcp_header_bytes});
                    end
                end else if (i_hdr.ip_protocol_num == PROTO_UDP) begin
                    if (i_n < l4s + 9'd4) begin
                        n_st = ST_SHORT;
                    end else begin
                        n_cls = CLS_UDP;
                        n_l4  = 1'b1;
                        n_pay = i_hdr.ip_total_bytes
                                - ({11'h000, i_hdr.ip_header_bytes} + UDP_HDR_BYTES);
                    end
                end else if (i_hdr.ip_protocol_num == PROTO_ICMP) begin
                    n_cls = CLS_ICMP;
                end else if (i_hdr.ip_protocol_num == PROTO_HOPOPT) begin
                    n_cls = CLS_IP_PROTO0;
                end else begin
                    n_cls = CLS_OTHER_IP;
                end
                if (n_st == ST_SHORT) begin
                    n_cls = CLS_UNKNOWN;
                    n_v4  = 1'b0;
                    n_l4  = 1'b0;
                end
            end
        end else if (i_hdr.ether_kind <= MAX_8023_LEN) begin
            n_cls = CLS_8023;
        end else if (i_hdr.ether_kind == ETYPE_ARP) begin
            n_cls = CLS_ARP;
        end else if (i_hdr.ether_kind == ETYPE_RARP) begin
            n_cls = CLS_RARP;
        end else if (i_hdr.ether_kind == ETYPE_LOOPBACK) begin
            n_cls = CLS_LOOPBACK;
        end
    end

    assign o_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_frame_class     <= n_cls;
            r_status          <= n_st;
            r_frame_length    <= i_wire_length;
            r_source_port     <= n_l4 ? i_hdr.l4_sport : 16'h0000;
            r_dest_port       <= n_l4 ? i_hdr.l4_dport : 16'h0000;
            r_tcp_flag_bits   <= n_tcp_ok ? i_hdr.tcp_ctl : 8'h00;
            r_tcp_sequence    <= n_tcp_ok ? i_hdr.tcp_seq : 32'h0;
            r_tcp_acknowledge <= n_tcp_ok ? i_hdr.tcp_ack : 32'h0;
            r_ip_ident        <= n_v4 ? i_hdr.ip_ident : 16'h0000;
            r_ip_service_type <= n_v4 ? i_hdr.ip_tos : 8'h00;
            r_ip_hop_limit    <= n_v4 ? i_hdr.ip_ttl : 8'h00;
            r_payload_length  <= n_l4 ? n_pay : 17'h0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_class     = r_frame_class;
    assign o_status          = r_status;
    assign o_frame_length    = r_frame_length;
    assign o_source_port     = r_source_port;
    assign o_dest_port       = r_dest_port;
    assign o_tcp_flag_bits   = r_tcp_flag_bits;
    assign o_tcp_sequence    = r_tcp_sequence;
    assign o_tcp_acknowledge = r_tcp_acknowledge;
    assign o_ip_ident        = r_ip_ident;
    assign o_ip_service_type = r_ip_service_type;
    assign o_ip_hop_limit    = r_ip_hop_limit;
    assign o_payload_length  = $signed(r_payload_length);

endmodule
